// File: hw/rtl/pdfa_pkg.sv
// ----------------------------------------------------------------------------
// pdfa_pkg
// Shared types and codes of the packed automaton matcher: item opcodes,
// result status codes, register indexes, table entry layouts.
// ----------------------------------------------------------------------------
package pdfa_pkg;

    localparam int STATE_W  = 8;
    localparam int ENTRY_W  = 10;
    localparam int BASE_W   = 11;
    localparam int MASK_W   = 8;
    localparam int RULE_W   = 15;
    localparam int LEN_W    = 16;
    localparam int STATUS_W = 3;
    localparam int TSIZE_W  = 11;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 1;
    // transition index: base plus masked byte, one extra bit for the sign
    localparam int IDX_W    = BASE_W + 1;

    typedef enum logic [1:0] {
        OP_WR_STATE = 2'd0,
        OP_WR_TRANS = 2'd1,
        OP_MATCH    = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_NONE   = 3'd0,
        STAT_RUN    = 3'd1,
        STAT_MATCH  = 3'd2,
        STAT_REJECT = 3'd3,
        STAT_END    = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_STATE = 1'd0,
        CFG_TABLE_SIZE  = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_CLEAR,
        PH_IDLE,
        PH_START,
        PH_TRANS,
        PH_STATE
    } t_phase;

    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [MASK_W-1:0]  mask;
        logic [RULE_W-1:0]  rule;
        logic               fin;
    } t_st_ent;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] owner;
        logic [STATE_W-1:0] next;
    } t_tr_ent;

    typedef struct packed {
        t_status            status;
        logic [RULE_W-1:0]  rule;
        logic [LEN_W-1:0]   len;
    } t_result;

endpackage

// File: hw/rtl/packed_dfa_prefix_matcher.sv
// ----------------------------------------------------------------------------
// packed_dfa_prefix_matcher
// Matches byte buffers against a row-displacement packed automaton held in a
// state table memory and a transition table memory.
// ----------------------------------------------------------------------------
// A match byte is a transition table read followed by the dependent state
// table read of the next state; the next byte enters in the cycle that read
// data returns, if the output queue is empty. The first byte of a buffer
// reads the start state entry first. Table writes, bytes after a decision and
// bytes decided from the current state alone are taken without a table read.
// Results go through a 2-entry output queue. After reset all NUM_TRANSITIONS
// transition table entries (at most 1024) are swept invalid while requests are
// stalled; configuration writes are taken throughout.
module packed_dfa_prefix_matcher #(
    parameter int NUM_STATES      = 256,
    parameter int NUM_TRANSITIONS = 1024,
    parameter int LENGTH_BITS     = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_op,
    input  logic [pdfa_pkg::ENTRY_W-1:0]      i_entry_index,
    input  logic signed [pdfa_pkg::BASE_W-1:0] i_base_offset,
    input  logic [pdfa_pkg::MASK_W-1:0]       i_byte_mask,
    input  logic [pdfa_pkg::RULE_W-1:0]       i_rule_number,
    input  logic                              i_is_final,
    input  logic [pdfa_pkg::STATE_W-1:0]      i_owner_state,
    input  logic [pdfa_pkg::STATE_W-1:0]      i_next_state,
    input  logic [7:0]                        i_in_byte,
    input  logic                              i_first,
    input  logic                              i_last,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [pdfa_pkg::STATUS_W-1:0]     o_status,
    output logic [pdfa_pkg::RULE_W-1:0]       o_rule_out,
    output logic [pdfa_pkg::LEN_W-1:0]        o_match_length,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [pdfa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pdfa_pkg::CFG_W-1:0]        i_cfg_wdata
);

    import pdfa_pkg::*;

    localparam int ST_DEPTH = (NUM_STATES < (1 << STATE_W)) ? NUM_STATES : (1 << STATE_W);
    localparam int ST_AW    = $clog2(ST_DEPTH);
    localparam int TR_DEPTH = (NUM_TRANSITIONS < (1 << ENTRY_W)) ?
                              NUM_TRANSITIONS : (1 << ENTRY_W);
    localparam int TR_AW    = $clog2(TR_DEPTH);
    localparam int ST_W     = $bits(t_st_ent);
    localparam int TR_W     = $bits(t_tr_ent);

    // control state
    t_phase                   r_phase, n_phase;
    logic [TR_AW-1:0]         r_clr, n_clr;
    logic [STATE_W-1:0]       r_cur_state, n_cur_state;
    logic [LENGTH_BITS-1:0]   r_count, n_count;
    logic                     r_decided, n_decided;
    logic                     r_fwd, n_fwd;
    logic                     r_st_oob, n_st_oob;
    logic [STATE_W-1:0]       r_start_state;
    logic [TSIZE_W-1:0]       r_table_size;

    // payload
    t_st_ent                  r_cur_ent, n_cur_ent;
    logic [7:0]               r_byte, n_byte;
    logic                     r_last, n_last;

    // output queue
    t_result                  r_fifo [2];
    logic [1:0]               r_cnt;
    logic                     r_rp, r_wp;
    logic                     push_a, push_b, pop;
    t_result                  res_a, res_b;
    t_result                  head;

    // memory ports
    logic                     st_we, st_re, tr_we, tr_re;
    logic [ST_AW-1:0]         st_waddr, st_raddr;
    logic [TR_AW-1:0]         tr_waddr, tr_raddr;
    t_st_ent                  st_wdata;
    t_tr_ent                  tr_wdata;
    logic [ST_W-1:0]          st_rdata;
    logic [TR_W-1:0]          tr_rdata;

    // datapath
    t_st_ent                  rd_ent, cur_ent;
    t_tr_ent                  tr_ent;
    logic                     can_acc, accept;
    logic [7:0]               ev_byte;
    logic                     ev_last;
    logic [IDX_W-1:0]         idx;
    logic                     idx_bad;
    logic [LENGTH_BITS+LEN_W-1:0] len_ext;
    logic [LEN_W-1:0]         len_cur;
    logic [LENGTH_BITS-1:0]   count_inc;
    logic                     st_wr_ok, st_rd_cur_ok, st_rd_start_ok;

    pdfa_ram #(.WIDTH(ST_W), .DEPTH(ST_DEPTH)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    pdfa_ram #(.WIDTH(TR_W), .DEPTH(TR_DEPTH)) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_waddr (tr_waddr),
        .i_wdata (tr_wdata),
        .i_re    (tr_re),
        .i_raddr (tr_raddr),
        .o_rdata (tr_rdata)
    );

    // state entries past the table read as zero
    assign rd_ent  = r_st_oob ? '0 : t_st_ent'(st_rdata);
    assign cur_ent = r_fwd ? rd_ent : r_cur_ent;
    assign tr_ent  = t_tr_ent'(tr_rdata);

    assign can_acc    = ((r_phase == PH_IDLE) && (r_cnt != 2'd2)) ||
                        ((r_phase == PH_STATE) && (r_cnt == 2'd0));
    assign o_in_stall = !can_acc;
    assign accept     = i_in_valid && can_acc;

    assign ev_byte = (r_phase == PH_START) ? r_byte : i_in_byte;
    assign ev_last = (r_phase == PH_START) ? r_last : i_last;
    assign idx     = {cur_ent.base[BASE_W-1], cur_ent.base} +
                     {{(IDX_W-8){1'b0}}, ev_byte & cur_ent.mask};
    assign idx_bad = idx[IDX_W-1] || (idx[IDX_W-2:0] >= r_table_size) ||
                     (32'(idx[IDX_W-2:0]) >= TR_DEPTH);

    assign len_ext   = {{LEN_W{1'b0}}, r_count};
    assign len_cur   = len_ext[LEN_W-1:0];
    assign count_inc = (&r_count) ? r_count : r_count + LENGTH_BITS'(1);

    assign st_wr_ok       = 32'(i_entry_index[STATE_W-1:0]) < ST_DEPTH;
    assign st_rd_cur_ok   = 32'(tr_ent.next) < ST_DEPTH;
    assign st_rd_start_ok = 32'(r_start_state) < ST_DEPTH;

    assign pop = o_out_valid && !i_out_stall;

    always_comb begin
        n_phase     = r_phase;
        n_clr       = r_clr;
        n_cur_state = r_cur_state;
        n_count     = r_count;
        n_decided   = r_decided;
        n_fwd       = 1'b0;
        n_st_oob    = r_st_oob;
        n_byte      = r_byte;
        n_last      = r_last;
        push_a      = 1'b0;
        push_b      = 1'b0;
        res_a       = '{status: STAT_NONE, rule: '0, len: '0};
        res_b       = '{status: STAT_NONE, rule: '0, len: '0};
        st_we       = 1'b0;
        st_waddr    = i_entry_index[ST_AW-1:0];
        st_wdata    = '{base: i_base_offset, mask: i_byte_mask, rule: i_rule_number,
                        fin: i_is_final};
        st_re       = 1'b0;
        st_raddr    = r_start_state[ST_AW-1:0];
        tr_we       = 1'b0;
        tr_waddr    = i_entry_index[TR_AW-1:0];
        tr_wdata    = '{valid: 1'b1, owner: i_owner_state, next: i_next_state};
        tr_re       = 1'b0;
        tr_raddr    = idx[TR_AW-1:0];

        unique case (r_phase)
            PH_CLEAR: begin
                tr_we    = 1'b1;
                tr_waddr = r_clr;
                tr_wdata = '0;
                n_clr    = r_clr + TR_AW'(1);
                if (r_clr == TR_AW'(TR_DEPTH - 1)) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_TRANS: begin
                if (!tr_ent.valid || (tr_ent.owner != r_cur_state)) begin
                    push_a       = 1'b1;
                    res_a.status = STAT_REJECT;
                    n_decided    = 1'b1;
                    n_phase      = PH_IDLE;
                end else begin
                    n_cur_state = tr_ent.next;
                    n_count     = count_inc;
                    st_re       = 1'b1;
                    st_raddr    = tr_ent.next[ST_AW-1:0];
                    n_st_oob    = !st_rd_cur_ok;
                    n_fwd       = 1'b1;
                    n_phase     = PH_STATE;
                end
            end
            PH_STATE: begin
                // finish the byte in flight; a new request may enter below
                push_a  = 1'b1;
                n_phase = PH_IDLE;
                if (rd_ent.fin) begin
                    res_a     = '{status: STAT_MATCH, rule: rd_ent.rule, len: len_cur};
                    n_decided = 1'b1;
                end else if (r_last) begin
                    res_a.status = STAT_END;
                    n_decided    = 1'b1;
                end else begin
                    res_a.status = STAT_RUN;
                end
            end
            default: begin
            end
        endcase

        if (accept) begin
            unique case (t_op'(i_op))
                OP_WR_STATE: begin
                    push_b = 1'b1;
                    st_we  = st_wr_ok;
                end
                OP_WR_TRANS: begin
                    push_b = 1'b1;
                    tr_we  = 32'(i_entry_index) < TR_DEPTH;
                end
                OP_MATCH: begin
                    if (i_first) begin
                        n_cur_state = r_start_state;
                        n_count     = '0;
                        n_decided   = 1'b0;
                        st_re       = 1'b1;
                        st_raddr    = r_start_state[ST_AW-1:0];
                        n_st_oob    = !st_rd_start_ok;
                        n_fwd       = 1'b1;
                        n_byte      = i_in_byte;
                        n_last      = i_last;
                        n_phase     = PH_START;
                    end else if (n_decided) begin
                        push_b = 1'b1;
                    end
                end
                default: begin
                    push_b = 1'b1;
                end
            endcase
        end

        // evaluate a byte against the current state entry
        if ((r_phase == PH_START) ||
            (accept && (i_op == OP_MATCH) && !i_first && !n_decided)) begin
            if (cur_ent.fin) begin
                push_b    = 1'b1;
                res_b     = '{status: STAT_MATCH, rule: cur_ent.rule, len: len_cur};
                n_decided = 1'b1;
                n_phase   = PH_IDLE;
            end else if (idx_bad) begin
                push_b       = 1'b1;
                res_b.status = STAT_REJECT;
                n_decided    = 1'b1;
                n_phase      = PH_IDLE;
            end else begin
                tr_re   = 1'b1;
                n_last  = ev_last;
                n_phase = PH_TRANS;
            end
        end

        // keep the current state entry coherent with state table writes
        n_cur_ent = r_fwd ? rd_ent : r_cur_ent;
        if (st_we && (i_entry_index[STATE_W-1:0] == r_cur_state)) begin
            n_cur_ent = st_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CLEAR;
            r_clr       <= '0;
            r_cur_state <= '0;
            r_count     <= '0;
            r_decided   <= 1'b1;
            r_fwd       <= 1'b0;
            r_st_oob    <= 1'b0;
            r_cnt       <= '0;
            r_rp        <= 1'b0;
            r_wp        <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_clr       <= n_clr;
            r_cur_state <= n_cur_state;
            r_count     <= n_count;
            r_decided   <= n_decided;
            r_fwd       <= n_fwd;
            r_st_oob    <= n_st_oob;
            r_cnt       <= r_cnt + 2'(push_a) + 2'(push_b) - 2'(pop);
            r_rp        <= r_rp ^ pop;
            r_wp        <= r_wp ^ push_a ^ push_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_ent <= n_cur_ent;
        r_byte    <= n_byte;
        r_last    <= n_last;
        // older result first when two land together
        if (push_a) begin
            r_fifo[r_wp] <= res_a;
        end
        if (push_b) begin
            r_fifo[r_wp ^ push_a] <= res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_table_size  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START_STATE: r_start_state <= i_cfg_wdata[STATE_W-1:0];
                CFG_TABLE_SIZE:  r_table_size  <= i_cfg_wdata[TSIZE_W-1:0];
            endcase
        end
    end

    assign head           = r_fifo[r_rp];
    assign o_out_valid    = r_cnt != 2'd0;
    assign o_status       = head.status;
    assign o_rule_out     = head.rule;
    assign o_match_length = head.len;

endmodule

// File: hw/rtl/pdfa_ram.sv
// ----------------------------------------------------------------------------
// pdfa_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module pdfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/pdfa_checker.sv
// ----------------------------------------------------------------------------
// pdfa_checker
// Port-level checks of the packed automaton matcher, bound to the top level.
// ----------------------------------------------------------------------------
module pdfa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_op,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [pdfa_pkg::STATUS_W-1:0] i_status,
    input  logic [pdfa_pkg::RULE_W-1:0]   i_rule_out,
    input  logic [pdfa_pkg::LEN_W-1:0]    i_match_length
);

    import pdfa_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=>
            i_out_valid && $stable(i_status) && $stable(i_rule_out) &&
            $stable(i_match_length))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present right after reset");

    // transition table sweep blocks requests after reset
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_stall)
        else $error("request taken during table clear");

    // writes and unused ops answer in the next cycle
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall && (i_op != OP_MATCH) |=> i_out_valid)
        else $error("no result for a write request");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != STAT_MATCH) |->
            (i_rule_out == '0) && (i_match_length == '0))
        else $error("rule or length set on a non-match result");

endmodule

bind packed_dfa_prefix_matcher pdfa_checker u_pdfa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .i_in_stall     (o_in_stall),
    .i_op           (i_op),
    .i_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .i_status       (o_status),
    .i_rule_out     (o_rule_out),
    .i_match_length (o_match_length)
);

// File: tb/packed_dfa_prefix_matcher_tb.sv
// ----------------------------------------------------------------------------
// packed_dfa_prefix_matcher_tb
// Self-checking bench for the packed automaton matcher: loads state and
// transition tables, walks byte buffers through them under random idling on
// both channels and compares every result against an in-bench predictor.
// ----------------------------------------------------------------------------
module packed_dfa_prefix_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdfa_pkg::*;

    localparam int N_STATES       = 256;
    localparam int N_TRANS        = 1024;
    localparam int LEN_BITS       = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TRAFFIC_QUOTA  = 150;

    typedef struct {
        logic [1:0]                op;
        logic [ENTRY_W-1:0]        entry;
        logic signed [BASE_W-1:0]  base;
        logic [MASK_W-1:0]         mask;
        logic [RULE_W-1:0]         rule;
        logic                      fin;
        logic [STATE_W-1:0]        owner;
        logic [STATE_W-1:0]        target;
        logic [7:0]                data;
        logic                      first;
        logic                      last;
    } t_match_req;

    typedef struct {
        t_status           status;
        logic [RULE_W-1:0] rule;
        logic [LEN_W-1:0]  len;
    } t_match_res;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [1:0]                 i_op = '0;
    logic [ENTRY_W-1:0]         i_entry_index = '0;
    logic signed [BASE_W-1:0]   i_base_offset = '0;
    logic [MASK_W-1:0]          i_byte_mask = '0;
    logic [RULE_W-1:0]          i_rule_number = '0;
    logic                       i_is_final = 1'b0;
    logic [STATE_W-1:0]         i_owner_state = '0;
    logic [STATE_W-1:0]         i_next_state = '0;
    logic [7:0]                 i_in_byte = '0;
    logic                       i_first = 1'b0;
    logic                       i_last = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [STATUS_W-1:0]        o_status;
    logic [RULE_W-1:0]          o_rule_out;
    logic [LEN_W-1:0]           o_match_length;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_W-1:0]           i_cfg_wdata = '0;

    // predicted automaton contents and match progress
    logic signed [BASE_W-1:0]   st_base [N_STATES];
    logic [MASK_W-1:0]          st_mask [N_STATES];
    logic [RULE_W-1:0]          st_rule [N_STATES];
    logic                       st_fin [N_STATES];
    logic                       tr_valid [N_TRANS];
    logic [STATE_W-1:0]         tr_owner [N_TRANS];
    logic [STATE_W-1:0]         tr_next [N_TRANS];
    logic [STATE_W-1:0]         cur_state;
    logic [LEN_W-1:0]           consumed;
    logic                       decided;
    logic [STATE_W-1:0]         cfg_start;
    logic [TSIZE_W-1:0]         cfg_tsize;

    // newest at the front, oldest at the back
    t_match_res pending_results [$];

    int  err_count = 0;
    int  n_requests = 0;
    int  n_results = 0;
    int  n_matched = 0;
    int  n_rejected = 0;
    int  n_ended = 0;
    int  quiet_cycles = 0;
    int  burst_left = 0;
    int  rx_left = 0;
    bit  rx_stalling = 1'b0;
    bit  idle_en = 1'b1;

    packed_dfa_prefix_matcher #(
        .NUM_STATES      (N_STATES),
        .NUM_TRANSITIONS (N_TRANS),
        .LENGTH_BITS     (LEN_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_entry_index  (i_entry_index),
        .i_base_offset  (i_base_offset),
        .i_byte_mask    (i_byte_mask),
        .i_rule_number  (i_rule_number),
        .i_is_final     (i_is_final),
        .i_owner_state  (i_owner_state),
        .i_next_state   (i_next_state),
        .i_in_byte      (i_in_byte),
        .i_first        (i_first),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_rule_out     (o_rule_out),
        .o_match_length (o_match_length),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic t_match_res step_automaton(input t_match_req r);
        t_match_res res;
        int idx;
        logic [STATE_W-1:0] s;
        res.status = STAT_NONE;
        res.rule = '0;
        res.len = '0;
        case (r.op)
            OP_WR_STATE: begin
                s = r.entry[STATE_W-1:0];
                st_base[s] = r.base;
                st_mask[s] = r.mask;
                st_rule[s] = r.rule;
                st_fin[s] = r.fin;
            end
            OP_WR_TRANS: begin
                tr_valid[r.entry] = 1'b1;
                tr_owner[r.entry] = r.owner;
                tr_next[r.entry] = r.target;
            end
            OP_MATCH: begin
                if (r.first) begin
                    cur_state = cfg_start;
                    consumed = '0;
                    decided = 1'b0;
                end
                if (!decided) begin
                    // a final state decides without consuming the byte
                    if (st_fin[cur_state]) begin
                        decided = 1'b1;
                        res.status = STAT_MATCH;
                        res.rule = st_rule[cur_state];
                        res.len = consumed;
                    end else begin
                        idx = int'(st_base[cur_state]) + int'(r.data & st_mask[cur_state]);
                        if (idx < 0 || idx >= int'(cfg_tsize) || idx >= N_TRANS ||
                                !tr_valid[idx] || tr_owner[idx] != cur_state) begin
                            decided = 1'b1;
                            res.status = STAT_REJECT;
                        end else begin
                            cur_state = tr_next[idx];
                            if (consumed != '1)
                                consumed = consumed + 1'b1;
                            if (st_fin[cur_state]) begin
                                decided = 1'b1;
                                res.status = STAT_MATCH;
                                res.rule = st_rule[cur_state];
                                res.len = consumed;
                            end else if (r.last) begin
                                decided = 1'b1;
                                res.status = STAT_END;
                            end else begin
                                res.status = STAT_RUN;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // mostly picks a byte with a live transition from the state it will meet
    function automatic logic [7:0] steer_byte(input logic first);
        logic [7:0] hits [$];
        logic [STATE_W-1:0] s;
        int idx;
        s = first ? cfg_start : cur_state;
        for (int b = 0; b < 256; b++) begin
            idx = int'(st_base[s]) + int'(8'(b) & st_mask[s]);
            if (idx >= 0 && idx < int'(cfg_tsize) && idx < N_TRANS && tr_valid[idx] &&
                    tr_owner[idx] == s)
                hits.push_front(8'(b));
        end
        if (hits.size() == 0 || $urandom_range(0, 9) == 0)
            return 8'($urandom);
        return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    function automatic t_match_req random_req();
        t_match_req r;
        r.op = 2'($urandom_range(0, 3));
        r.entry = ENTRY_W'($urandom);
        r.base = BASE_W'($urandom);
        r.mask = MASK_W'($urandom);
        r.rule = RULE_W'($urandom);
        r.fin = 1'($urandom);
        r.owner = STATE_W'($urandom);
        r.target = STATE_W'($urandom);
        r.data = 8'($urandom);
        r.first = 1'($urandom);
        r.last = 1'($urandom);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_req(input t_match_req r);
        t_match_res res;
        int gap;
        if (idle_en && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_op          <= r.op;
        i_entry_index <= r.entry;
        i_base_offset <= r.base;
        i_byte_mask   <= r.mask;
        i_rule_number <= r.rule;
        i_is_final    <= r.fin;
        i_owner_state <= r.owner;
        i_next_state  <= r.target;
        i_in_byte     <= r.data;
        i_first       <= r.first;
        i_last        <= r.last;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        res = step_automaton(r);
        pending_results.push_front(res);
        n_requests++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic put_state(input logic [ENTRY_W-1:0] entry,
                             input logic signed [BASE_W-1:0] base,
                             input logic [MASK_W-1:0] mask,
                             input logic [RULE_W-1:0] rule, input logic fin);
        t_match_req r;
        r = random_req();
        r.op = OP_WR_STATE;
        r.entry = entry;
        r.base = base;
        r.mask = mask;
        r.rule = rule;
        r.fin = fin;
        send_req(r);
    endtask

    task automatic put_trans(input logic [ENTRY_W-1:0] entry,
                             input logic [STATE_W-1:0] owner,
                             input logic [STATE_W-1:0] target);
        t_match_req r;
        r = random_req();
        r.op = OP_WR_TRANS;
        r.entry = entry;
        r.owner = owner;
        r.target = target;
        send_req(r);
    endtask

    task automatic put_byte(input logic [7:0] data, input logic first, input logic last);
        t_match_req r;
        r = random_req();
        r.op = OP_MATCH;
        r.data = data;
        r.first = first;
        r.last = last;
        send_req(r);
    endtask

    // drop valid and wait until every pending result is back
    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [STATE_W-1:0] start, input logic [TSIZE_W-1:0] tsize);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_START_STATE;
        // upper bits are don't care for the start state
        i_cfg_wdata <= {3'($urandom), start};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_TABLE_SIZE;
        i_cfg_wdata <= tsize;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_start = start;
        cfg_tsize = tsize;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_ignored_requests();
        t_match_req r;
        // no buffer active after reset
        put_byte(8'h00, 1'b0, 1'b0);
        put_byte(8'hFF, 1'b0, 1'b1);
        r = random_req();
        r.op = OP_UNUSED;
        send_req(r);
    endtask

    task automatic load_state_table();
        for (int s = 0; s < N_STATES; s++)
            put_state({2'($urandom), 8'(s)}, BASE_W'($urandom), 8'($urandom),
                      RULE_W'($urandom), $urandom_range(0, 5) == 0);
    endtask

    task automatic test_directed_paths();
        t_match_req r;
        configure(8'd0, 11'd1024);
        put_state(10'h000, 11'sd1020, 8'hFF, RULE_W'($urandom), 1'b0);
        put_state(10'h3FF, -11'sd255, 8'hFF, 15'd0, 1'b0);
        // most negative base
        put_state(10'h107, 11'h400, 8'hFF, 15'h7FFF, 1'b1);
        put_trans(10'd1023, 8'd0, 8'd255);
        put_trans(10'd0, 8'd255, 8'd7);
        put_trans(10'd1021, 8'd9, 8'd7);
        // final reached on a last byte
        put_byte(8'd3, 1'b1, 1'b0);
        put_byte(8'd255, 1'b0, 1'b1);
        put_byte(8'h00, 1'b0, 1'b0);
        // index past the table
        put_byte(8'd4, 1'b1, 1'b1);
        put_byte(8'd3, 1'b1, 1'b1);
        // negative index
        put_byte(8'd3, 1'b1, 1'b0);
        put_byte(8'd0, 1'b0, 1'b0);
        // foreign owner, then never written entry
        put_byte(8'd1, 1'b1, 1'b0);
        put_byte(8'd2, 1'b1, 1'b0);
        r = random_req();
        r.op = OP_UNUSED;
        send_req(r);
        // final start state matches with length zero
        configure(8'd7, 11'd0);
        put_byte(8'($urandom), 1'b1, 1'b0);
        put_byte(8'($urandom), 1'b0, 1'b1);
        configure(8'd0, 11'd0);
        put_byte(8'd3, 1'b1, 1'b0);
        configure(8'd255, 11'd2047);
        put_byte(8'd255, 1'b1, 1'b1);
        configure(8'd0, 11'd1023);
        put_byte(8'd3, 1'b1, 1'b0);
    endtask

    task automatic build_automaton(input int n_states);
        logic [STATE_W-1:0] members [$];
        logic [STATE_W-1:0] s;
        logic [MASK_W-1:0] mask;
        logic fin;
        int lim, base, idx, n_arcs;
        while (members.size() < n_states - 1)
            members.push_front(STATE_W'($urandom));
        // the start state always sits at the head
        members.push_front(cfg_start);
        lim = (cfg_tsize > N_TRANS) ? N_TRANS : int'(cfg_tsize);
        foreach (members[i]) begin
            s = members[i];
            case ($urandom_range(0, 3))
                0: mask = 8'hFF;
                1: mask = 8'h0F;
                2: mask = 8'h07;
                default: mask = 8'($urandom);
            endcase
            if ($urandom_range(0, 7) == 0)
                base = int'($urandom_range(0, 2047)) - 1024;
            else
                base = int'($urandom_range(0, (lim > 0) ? lim - 1 : 0)) -
                       int'($urandom_range(0, 8));
            fin = (i == 0) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 3) == 0);
            put_state({2'($urandom), s}, BASE_W'(base), mask, RULE_W'($urandom), fin);
            if (!fin) begin
                n_arcs = $urandom_range(2, 6);
                for (int k = 0; k < n_arcs; k++) begin
                    idx = base + int'(8'($urandom) & mask);
                    if (idx >= 0 && idx < N_TRANS)
                        put_trans(ENTRY_W'(idx), s,
                                  members[$urandom_range(0, members.size() - 1)]);
                end
            end
        end
    endtask

    task automatic run_traffic(input int quota);
        int stop, len;
        stop = n_requests + quota;
        while (n_requests < stop) begin
            if ($urandom_range(0, 7) == 0) begin
                send_req(random_req());
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                // some buffers lose their last flag
                for (int k = 0; k < len; k++)
                    put_byte(steer_byte(k == 0), k == 0,
                             (k == len - 1) && ($urandom_range(0, 15) != 0));
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: configure(STATE_W'($urandom), 11'd1024);
                1: configure(8'd0, TSIZE_W'($urandom_range(1, 1024)));
                2: configure(8'd255, 11'd2047);
                3: configure(STATE_W'($urandom), TSIZE_W'($urandom_range(16, 128)));
                default: configure(STATE_W'($urandom), TSIZE_W'($urandom_range(512, 1024)));
            endcase
            build_automaton($urandom_range(3, 10));
            run_traffic(TRAFFIC_QUOTA);
        end
    endtask

    // ------------------------------------------------------------------
    // result side: stall pattern and checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_match_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: status %0d", o_status);
                err_count++;
            end else begin
                want = pending_results.pop_back();
                n_results++;
                case (want.status)
                    STAT_MATCH:  n_matched++;
                    STAT_REJECT: n_rejected++;
                    STAT_END:    n_ended++;
                    default: ;
                endcase
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_count++;
                end
                if (o_rule_out !== want.rule) begin
                    $error("rule_out: expected %0d, got %0d", want.rule, o_rule_out);
                    err_count++;
                end
                if (o_match_length !== want.len) begin
                    $error("match_length: expected %0d, got %0d", want.len, o_match_length);
                    err_count++;
                end
            end
        end
        if (rx_left == 0) begin
            rx_stalling = rx_stalling ? 1'b0 : ($urandom_range(0, 2) != 0);
            rx_left = rx_stalling ? $urandom_range(1, 5) : $urandom_range(1, 20);
        end
        rx_left--;
        i_out_stall <= idle_en && rx_stalling;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    initial begin
        for (int s = 0; s < N_STATES; s++) begin
            st_base[s] = '0;
            st_mask[s] = '0;
            st_rule[s] = '0;
            st_fin[s] = 1'b0;
        end
        for (int t = 0; t < N_TRANS; t++) begin
            tr_valid[t] = 1'b0;
            tr_owner[t] = '0;
            tr_next[t] = '0;
        end
        cur_state = '0;
        consumed = '0;
        decided = 1'b1;
        cfg_start = '0;
        cfg_tsize = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ignored_requests();
        load_state_table();
        test_directed_paths();
        test_random_traffic();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("checked %0d results from %0d requests: %0d matched, %0d rejected, %0d unmatched",
                 n_results, n_requests, n_matched, n_rejected, n_ended);
        $display("covered ignored and directed paths plus 6 random table sets under idling");
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/pdfa_pkg.sv
hw/rtl/pdfa_ram.sv
hw/rtl/packed_dfa_prefix_matcher.sv
hw/rtl/pdfa_checker.sv
tb/packed_dfa_prefix_matcher_tb.sv
